FILE: rtl/escaped_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// escaped_frame_receiver_assert.svh
// Assertion macros for the escaped frame receiver.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// checked on clk, masked while rst_n is low
`define EFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on clk at every edge, reset included
`define EFR_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFR_ASSERT_RST(lbl, prop, msg)
`define EFR_ASSERT_ALL(lbl, prop, msg)
`endif

`endif

FILE: rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared constants, types and the payload position table.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int CFG_W        = 6;
  localparam int CMP_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PAYLOAD_LEN  = 10;
  localparam int SLOT_W       = 4;

  localparam logic [7:0] START_BYTE  = 8'hAA;
  localparam logic [7:0] ESCAPE_BYTE = 8'hFF;
  localparam logic [7:0] END_BYTE    = 8'h55;
  localparam logic [CFG_W-1:0] MIN_FRAME_RST = 6'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } efr_state_t;

  typedef struct packed {
    logic take;   // process the input item
    logic rd;     // read buffer at current slot
    logic next;   // advance to the next slot
  } efr_cmd_t;

  typedef struct packed {
    logic emit;   // current input item ends a kept frame
    logic last;   // current slot is the final one
  } efr_stat_t;

  // buffer position of each payload slot
  function automatic logic [IDX_W-1:0] payload_pos(input logic [SLOT_W-1:0] slot);
    logic [IDX_W-1:0] pos;
    case (slot)
      4'd0:    pos = IDX_W'(5);
      4'd1:    pos = IDX_W'(6);
      4'd2:    pos = IDX_W'(7);
      4'd3:    pos = IDX_W'(12);
      4'd4:    pos = IDX_W'(13);
      4'd5:    pos = IDX_W'(14);
      4'd6:    pos = IDX_W'(15);
      4'd7:    pos = IDX_W'(16);
      4'd8:    pos = IDX_W'(17);
      4'd9:    pos = IDX_W'(18);
      default: pos = '0;
    endcase
    return pos;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/efr_ctrl.sv
// ----------------------------------------------------------------------------
// efr_ctrl
// Sequencer: takes items, then walks the payload readout on a frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire efr_pkg::efr_stat_t stat,
  output efr_pkg::efr_cmd_t      cmd
);
  import efr_pkg::*;

  efr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.emit) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.next  = 1'b1;
          state_nxt = stat.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/efr_dpath.sv
// ----------------------------------------------------------------------------
// efr_dpath
// Frame buffer, fill/escape/overflow state and payload readout registers.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [7:0]                 in_rx_byte,
  input  wire logic                       cfg_valid,
  input  wire logic [efr_pkg::CFG_W-1:0]  cfg_min_frame_bytes,
  input  wire efr_pkg::efr_cmd_t          cmd,
  output efr_pkg::efr_stat_t              stat,
  output logic [7:0]                      out_payload_byte,
  output logic [efr_pkg::SLOT_W-1:0]      out_payload_slot,
  output logic                            out_last_of_run,
  output logic                            out_frame_overflowed
);
  import efr_pkg::*;

  logic [7:0]        mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] vld_r;

  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              esc_r, esc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CFG_W-1:0]  min_r;
  logic [SLOT_W-1:0] slot_r;
  logic              run_ovf_r;
  logic [7:0]        rd_data_r;
  logic              rd_vld_r;

  logic              full;
  logic              short;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  base;
  logic [IDX_W-1:0]  rd_idx;

  assign full   = (fill_r == CNT_W'(BUFFER_DEPTH));
  assign short  = (CMP_W'(fill_r) < CMP_W'(min_r));
  assign rd_idx = payload_pos(slot_r);

  assign stat.emit = !esc_r && (in_rx_byte == END_BYTE) && !short;
  assign stat.last = (slot_r == SLOT_W'(PAYLOAD_LEN - 1));

  // decode of one received byte
  always_comb begin
    esc_nxt = esc_r;
    ovf_nxt = ovf_r;
    wr_en   = 1'b0;
    base    = fill_r;
    if (esc_r) begin
      wr_en   = 1'b1;
      esc_nxt = 1'b0;
    end else if (in_rx_byte == START_BYTE) begin
      base    = '0;
      ovf_nxt = 1'b0;
      wr_en   = 1'b1;
    end else if (in_rx_byte == ESCAPE_BYTE) begin
      esc_nxt = 1'b1;
    end else if (in_rx_byte != END_BYTE) begin
      wr_en = 1'b1;
    end else if (!short) begin
      wr_en = 1'b1;
    end
    wr_idx   = base[IDX_W-1:0];
    fill_nxt = base;
    if (wr_en) begin
      if (base == CNT_W'(BUFFER_DEPTH)) begin
        ovf_nxt = 1'b1;
        wr_en   = 1'b0;
      end else begin
        fill_nxt = base + CNT_W'(1);
      end
    end
    // frame end: kept or dropped, position and flag restart
    if (!esc_r && (in_rx_byte == END_BYTE)) begin
      fill_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      esc_r  <= 1'b0;
      ovf_r  <= 1'b0;
      vld_r  <= '0;
      min_r  <= MIN_FRAME_RST;
      slot_r <= '0;
    end else begin
      if (cfg_valid) begin
        min_r <= cfg_min_frame_bytes;
      end
      if (cmd.take) begin
        fill_r <= fill_nxt;
        esc_r  <= esc_nxt;
        ovf_r  <= ovf_nxt;
        if (wr_en) begin
          vld_r[wr_idx] <= 1'b1;
        end
        if (stat.emit) begin
          slot_r <= '0;
        end
      end else if (cmd.next) begin
        slot_r <= stat.last ? '0 : slot_r + SLOT_W'(1);
      end
    end
  end

  // frame buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[wr_idx] <= in_rx_byte;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_idx];
      rd_vld_r  <= vld_r[rd_idx];
    end
  end

  // overflow flag of the emitted frame, end byte included
  always_ff @(posedge clk) begin
    if (cmd.take && stat.emit) begin
      run_ovf_r <= ovf_r || full;
    end
  end

  assign out_payload_byte     = rd_vld_r ? rd_data_r : 8'h00;
  assign out_payload_slot     = slot_r;
  assign out_last_of_run      = stat.last;
  assign out_frame_overflowed = run_ovf_r;

endmodule

`default_nettype wire

FILE: rtl/escaped_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Frames received serial bytes and emits ten payload bytes per kept frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one received byte (in_rx_byte).
//   A byte is taken on an edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall carry one payload item (byte,
//   slot 0..9, last flag, overflow flag); the item holds while stalled.
//   Config: cfg_valid / cfg_ready write min_frame_bytes; cfg_ready is
//   always high. Write it only while the block is idle.
// Sequence:
//   For ordinary bytes in_stall stays low, so outside a readout a new
//   byte can be taken every cycle. A frame end that keeps the frame
//   starts a readout: each payload item passes a buffer read state and
//   then a send state, in which out_valid is high. in_stall is high for
//   the whole readout. Each item has its own read state because the
//   buffer has a single read port. out_stall holds the current item in
//   its send state.
// Reset:
//   rst_n (sync, active low) clears fill position, escape mark, overflow
//   flag and all buffer valid bits (unwritten entries read as zero), and
//   loads min_frame_bytes with 3. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_receiver (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // received byte channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_rx_byte,
  // payload channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_payload_byte,
  output logic [efr_pkg::SLOT_W-1:0]     out_payload_slot,
  output logic                           out_last_of_run,
  output logic                           out_frame_overflowed,
  // min_frame_bytes write port
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [efr_pkg::CFG_W-1:0] cfg_min_frame_bytes
);
  import efr_pkg::*;

  efr_cmd_t  cmd;
  efr_stat_t stat;

  // register write never waits
  assign cfg_ready = 1'b1;

  // sequencer: item intake and payload walk
  efr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // buffer, frame state and readout registers
  efr_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_rx_byte           (in_rx_byte),
    .cfg_valid            (cfg_valid),
    .cfg_min_frame_bytes  (cfg_min_frame_bytes),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_payload_byte     (out_payload_byte),
    .out_payload_slot     (out_payload_slot),
    .out_last_of_run      (out_last_of_run),
    .out_frame_overflowed (out_frame_overflowed)
  );

`include "escaped_frame_receiver_assert.svh"

  // no intake while a payload item is pending
  `EFR_ASSERT_RST(a_no_take_in_run, out_valid |-> in_stall, "byte taken during readout")
  // last item sent returns to idle
  `EFR_ASSERT_RST(a_last_ends, out_valid && !out_stall && out_last_of_run |=> !out_valid, "run continued past last item")
  // next item follows after a buffer read state
  `EFR_ASSERT_RST(a_run_pace, out_valid && !out_stall && !out_last_of_run |=> !out_valid ##1 out_valid, "payload run broke off")
  // nothing pending right after reset
  `EFR_ASSERT_ALL(a_reset_quiet, !rst_n |=> !out_valid, "output valid after reset")

endmodule

`default_nettype wire
